@@ hw/rtl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Used by the channel interfaces and by every module of the block but dq_ram.
package dq_pkg;

    localparam int FUNC_W    = 3;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 64;

    // Input function codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HALT  = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_F,
        OP_PUSH_R,
        OP_POP_F,
        OP_POP_R,
        OP_LIST,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] element;
        logic                     element_valid;
        logic                     last;
    } t_res;

    typedef enum logic {
        BS_IDLE,
        BS_LIST
    } t_bstate;

    // Command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = 1;
    localparam int CQ_CW    = 2;

endpackage

@@ hw/rtl/dq_in_if.sv @@
// Input channel of the double-ended queue: operation code and push value.
// Depends on dq_pkg for field widths.
interface dq_in_if;
    logic                              valid;
    logic                              ready;
    logic [dq_pkg::FUNC_W-1:0]         func;
    logic signed [dq_pkg::DATA_W-1:0]  value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

@@ hw/rtl/dq_out_if.sv @@
// Result channel of the double-ended queue: status and listed elements.
// Depends on dq_pkg for field widths.
interface dq_out_if;
    logic                              valid;
    logic                              ready;
    logic [dq_pkg::STATUS_W-1:0]       status;
    logic signed [dq_pkg::DATA_W-1:0]  element;
    logic                              element_valid;
    logic                              last;

    modport source (output valid, status, element, element_valid, last, input ready);
    modport sink   (input valid, status, element, element_valid, last, output ready);
endinterface

@@ hw/rtl/dq_ram.sv @@
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/dq_front.sv @@
// Front end: accepts input transfers, decodes the function code and
// buffers commands in a short queue for the back end. Depends on dq_pkg.
module dq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dq_in_if.sink         i_cmd,
    output logic          o_cmd_valid,
    output dq_pkg::t_cmd  o_cmd,
    input  logic          i_cmd_take
);
    import dq_pkg::*;

    t_cmd             r_slot [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr;
    logic [CQ_AW-1:0] r_rd_ptr;
    logic [CQ_CW-1:0] r_fill;
    logic             push;
    logic             pop;
    t_cmd             dec;

    always_comb begin
        dec.value = i_cmd.value;
        case (i_cmd.func)
            FN_PUSH_FRONT: dec.op = OP_PUSH_F;
            FN_PUSH_REAR:  dec.op = OP_PUSH_R;
            FN_POP_FRONT:  dec.op = OP_POP_F;
            FN_POP_REAR:   dec.op = OP_POP_R;
            FN_LIST:       dec.op = OP_LIST;
            default:       dec.op = OP_NONE;
        endcase
    end

    assign i_cmd.ready = (r_fill != CQ_CW'(CQ_DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end
endmodule

@@ hw/rtl/dq_back.sv @@
// Back end: executes queued commands on the ring store, keeps head, count
// and halted state, and drives the registered result channel.
// Depends on dq_pkg and dq_ram.
module dq_back #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  dq_pkg::t_cmd  i_cmd,
    output logic          o_cmd_take,
    dq_out_if.source      o_res
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    t_bstate           r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic              r_halted, n_halted;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              out_free;
    logic              cmd_take;
    logic              list_load;
    logic              full;
    logic              empty;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [AW-1:0]     slot_rear;
    logic [AW-1:0]     slot_rd;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;
    logic [SW-1:0]     sum_rear;
    logic [SW-1:0]     sum_rd;

    // ring position = (head + offset) mod DEPTH, offset at most DEPTH
    always_comb begin
        sum_rear  = SW'(r_head) + SW'(r_count);
        sum_rd    = SW'(r_head) + SW'(r_rd_idx);
        slot_rear = (sum_rear >= SW'(DEPTH)) ? AW'(sum_rear - SW'(DEPTH)) : AW'(sum_rear);
        slot_rd   = (sum_rd >= SW'(DEPTH)) ? AW'(sum_rd - SW'(DEPTH)) : AW'(sum_rd);
        head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
        head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    end

    assign out_free   = !r_out_valid || o_res.ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign cmd_take   = (r_state == BS_IDLE) && i_cmd_valid && out_free;
    assign list_load  = (r_state == BS_LIST) && r_pend && out_free;
    assign o_cmd_take = cmd_take;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (cmd_take && !r_halted && i_cmd.op == OP_LIST && !empty) begin
                    n_state = BS_LIST;
                end
            end
            BS_LIST: begin
                if (list_load && r_pend_last) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_halted    = r_halted;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = slot_rear;
        ram_re      = 1'b0;
        ram_raddr   = slot_rd;

        case (r_state)
            BS_IDLE: begin
                if (cmd_take) begin
                    n_out.status        = ST_OK;
                    n_out.element       = '0;
                    n_out.element_valid = 1'b0;
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    if (r_halted) begin
                        n_out.status = ST_HALT;
                    end else begin
                        case (i_cmd.op)
                            OP_PUSH_F, OP_PUSH_R: begin
                                if (full) begin
                                    n_out.status = ST_OVER;
                                end else begin
                                    ram_we  = 1'b1;
                                    n_count = r_count + 1'b1;
                                    if (i_cmd.op == OP_PUSH_F) begin
                                        ram_waddr = head_dec;
                                        n_head    = head_dec;
                                    end
                                end
                            end
                            OP_POP_F, OP_POP_R: begin
                                if (empty) begin
                                    n_out.status = ST_UNDER;
                                    n_halted     = 1'b1;
                                end else begin
                                    n_count = r_count - 1'b1;
                                    if (i_cmd.op == OP_POP_F) begin
                                        n_head = head_inc;
                                    end
                                end
                            end
                            OP_LIST: begin
                                if (!empty) begin
                                    // first read; results come from BS_LIST
                                    n_out_valid = 1'b0;
                                    ram_re      = 1'b1;
                                    ram_raddr   = r_head;
                                    n_rd_idx    = CW'(1);
                                    n_pend      = 1'b1;
                                    n_pend_last = (r_count == CW'(1));
                                end
                            end
                            default: begin
                                // unused code: no result
                                n_out_valid = 1'b0;
                            end
                        endcase
                    end
                end
            end
            BS_LIST: begin
                if (list_load) begin
                    n_out.status        = ST_OK;
                    n_out.element       = ram_rdata;
                    n_out.element_valid = 1'b1;
                    n_out.last          = r_pend_last;
                    n_out_valid         = 1'b1;
                    n_pend              = 1'b0;
                end
                // advance the read stream while the next slot is free
                if (r_rd_idx != r_count && (!r_pend || list_load)) begin
                    ram_re      = 1'b1;
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_rd_idx + 1'b1 == r_count);
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.element       = r_out.element;
    assign o_res.element_valid = r_out.element_valid;
    assign o_res.last          = r_out.last;
endmodule

@@ hw/rtl/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit elements in a ring store of DEPTH
// entries. i_cmd carries one operation per transfer (func, value): push
// front, push rear, pop front, pop rear or list. o_res returns status,
// element, element_valid and last; every item that causes results ends
// with last set, unused function codes give no result unless halted.
// A status result passes from the front command queue into the result
// register; the first element of a list comes after the store read.
// Pushes and pops can be taken back to back while o_res accepts results.
// A list reads its elements in turn through the ring store's single
// registered read port; no new command starts until the list is done.
// Full: a push is dropped and reports overflow. A pop of an empty deque
// reports underflow and halts the block: every later item reports halted
// until reset. Reset empties the deque and clears halted; store contents
// are not cleared and need no clearing pass.
// When o_res is stalled the result register holds, the back end stops
// taking commands and the two-entry front queue fills, then drops ready.
// Depends on dq_pkg, dq_in_if, dq_out_if, dq_front, dq_back, dq_ram.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dq_in_if.sink      i_cmd,
    dq_out_if.source   o_res
);
    import dq_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    dq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res       (o_res)
    );
endmodule
